@@ src/rdc_pkg.sv @@
`timescale 1ns / 1ps

package rdc_pkg;

	localparam int CNT_W       = 14;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		STEP_INIT,
		STEP_GROW_HI,
		STEP_GROW_LO,
		STEP_SHR_HI,
		STEP_SHR_LO,
		STEP_WR_OLD,
		STEP_WR_NEW
	} step_t;

	typedef struct packed {
		logic  load_item;
		logic  clr_en;
		logic  vs_wr;
		logic  vs_rd;
		logic  h_rd;
		logic  h_wr;
		logic  resp_load;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic kind;
		logic empty;
		logic in_win;
		logic range_bad;
		logic grow_hi;
		logic grow_lo;
		logic shr_hi;
		logic shr_lo;
		logic out_busy;
	} status_t;

endpackage

@@ src/rdc_ctrl.sv @@
`timescale 1ns / 1ps

module rdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  rdc_pkg::status_t st,
	output rdc_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_VRD    = 7'b0001000,
		ST_HRD    = 7'b0010000,
		ST_HWR    = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	rdc_pkg::step_t step_q, step_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		cmd.step = step_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!st.kind) begin
					if (st.in_win) begin
						step_d  = rdc_pkg::STEP_WR_OLD;
						state_d = ST_VRD;
					end else begin
						cmd.vs_wr = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (st.range_bad) begin
					state_d = ST_RESP;
				end else if (st.empty) begin
					step_d  = rdc_pkg::STEP_INIT;
					state_d = ST_VRD;
				end else if (st.grow_hi) begin
					step_d  = rdc_pkg::STEP_GROW_HI;
					state_d = ST_VRD;
				end else if (st.grow_lo) begin
					step_d  = rdc_pkg::STEP_GROW_LO;
					state_d = ST_VRD;
				end else if (st.shr_hi) begin
					step_d  = rdc_pkg::STEP_SHR_HI;
					state_d = ST_VRD;
				end else if (st.shr_lo) begin
					step_d  = rdc_pkg::STEP_SHR_LO;
					state_d = ST_VRD;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_VRD: begin
				cmd.vs_rd = 1'b1;
				state_d   = ST_HRD;
			end
			ST_HRD: begin
				cmd.h_rd = 1'b1;
				state_d  = ST_HWR;
			end
			ST_HWR: begin
				cmd.h_wr = 1'b1;
				if (step_q == rdc_pkg::STEP_WR_OLD) begin
					step_d  = rdc_pkg::STEP_WR_NEW;
					state_d = ST_HRD;
				end else if (step_q == rdc_pkg::STEP_WR_NEW) begin
					cmd.vs_wr = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_RESP: begin
				if (!st.out_busy) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= rdc_pkg::STEP_INIT;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_tvalid) |=> (state_q == ST_DECIDE))
		else $error("accepted beat not decoded");

	a_wr_new_follows_old: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HWR && step_q == rdc_pkg::STEP_WR_OLD)
		|=> (state_q == ST_HRD && step_q == rdc_pkg::STEP_WR_NEW))
		else $error("write update lost its second half");

endmodule

@@ src/rdc_dp.sv @@
`timescale 1ns / 1ps

module rdc_dp #(
	parameter int PB = 13,
	parameter int VB = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rdc_pkg::cmd_t             cmd,
	output rdc_pkg::status_t          st,
	input  logic                      kind,
	input  logic [PB-1:0]             position,
	input  logic [VB-1:0]             new_value,
	input  logic [PB-1:0]             range_lo,
	input  logic [PB-1:0]             range_hi,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rdc_pkg::CNT_W-1:0] distinct_count,
	output logic                      range_error
);

	localparam int CW = rdc_pkg::CNT_W;

	logic          kind_q;
	logic [PB-1:0] pos_q, rlo_q, rhi_q;
	logic [VB-1:0] nv_q;

	logic [PB-1:0] lo_q, hi_q;
	logic          empty_q;
	logic [CW-1:0] total_q;
	logic [VB-1:0] clr_q;

	logic [VB-1:0] vs_mem [2**PB];
	logic [VB-1:0] vs_rdata_q;
	logic [PB-1:0] vs_addr;

	logic [CW-1:0] h_mem [2**VB];
	logic [CW-1:0] h_rdata_q;
	logic [VB-1:0] hval;
	logic          enter;
	logic [CW-1:0] h_new;
	logic          h_we;
	logic [VB-1:0] h_waddr;
	logic [CW-1:0] h_wdata;

	logic          out_valid_q;
	logic [CW-1:0] count_q;
	logic          err_q;

	always_comb begin
		st.clr_last  = (clr_q == {VB{1'b1}});
		st.kind      = kind_q;
		st.empty     = empty_q;
		st.in_win    = !empty_q && (lo_q <= pos_q) && (pos_q <= hi_q);
		st.range_bad = (rlo_q > rhi_q);
		st.grow_hi   = (hi_q < rhi_q);
		st.grow_lo   = (lo_q > rlo_q);
		st.shr_hi    = (hi_q > rhi_q);
		st.shr_lo    = (lo_q < rlo_q);
		st.out_busy  = out_valid_q && !out_ready;
	end

	always_comb begin
		case (cmd.step)
			rdc_pkg::STEP_INIT:    vs_addr = rlo_q;
			rdc_pkg::STEP_GROW_HI: vs_addr = hi_q + PB'(1);
			rdc_pkg::STEP_GROW_LO: vs_addr = lo_q - PB'(1);
			rdc_pkg::STEP_SHR_HI:  vs_addr = hi_q;
			rdc_pkg::STEP_SHR_LO:  vs_addr = lo_q;
			default:               vs_addr = pos_q;
		endcase
	end

	assign hval  = (cmd.step == rdc_pkg::STEP_WR_NEW) ? nv_q : vs_rdata_q;
	assign enter = (cmd.step == rdc_pkg::STEP_INIT) || (cmd.step == rdc_pkg::STEP_GROW_HI) ||
	               (cmd.step == rdc_pkg::STEP_GROW_LO) || (cmd.step == rdc_pkg::STEP_WR_NEW);
	assign h_new = enter ? (h_rdata_q + CW'(1)) : (h_rdata_q - CW'(1));

	assign h_we    = cmd.clr_en || cmd.h_wr;
	assign h_waddr = cmd.clr_en ? clr_q : hval;
	assign h_wdata = cmd.clr_en ? '0 : h_new;

	// value store
	always_ff @(posedge clk) begin
		if (cmd.vs_wr) begin
			vs_mem[pos_q] <= nv_q;
		end
		if (cmd.vs_rd) begin
			vs_rdata_q <= vs_mem[vs_addr];
		end
	end

	// histogram
	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[h_waddr] <= h_wdata;
		end
		if (cmd.h_rd) begin
			h_rdata_q <= h_mem[hval];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			pos_q  <= position;
			nv_q   <= new_value;
			rlo_q  <= range_lo;
			rhi_q  <= range_hi;
		end
		if (cmd.resp_load) begin
			count_q <= st.range_bad ? '0 : total_q;
			err_q   <= st.range_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= '0;
			hi_q        <= '0;
			empty_q     <= 1'b1;
			total_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + VB'(1);
			end
			if (cmd.h_wr) begin
				if (enter && h_rdata_q == '0) begin
					total_q <= total_q + CW'(1);
				end else if (!enter && h_rdata_q == CW'(1)) begin
					total_q <= total_q - CW'(1);
				end
				case (cmd.step)
					rdc_pkg::STEP_INIT: begin
						lo_q    <= rlo_q;
						hi_q    <= rlo_q;
						empty_q <= 1'b0;
					end
					rdc_pkg::STEP_GROW_HI: hi_q <= hi_q + PB'(1);
					rdc_pkg::STEP_GROW_LO: lo_q <= lo_q - PB'(1);
					rdc_pkg::STEP_SHR_HI:  hi_q <= hi_q - PB'(1);
					rdc_pkg::STEP_SHR_LO:  lo_q <= lo_q + PB'(1);
					default: ;
				endcase
			end
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign distinct_count = count_q;
	assign range_error    = err_q;

	a_window_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (lo_q <= hi_q))
		else $error("window bounds crossed");

	a_grow_hi_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.h_wr && cmd.step == rdc_pkg::STEP_GROW_HI) |=> (hi_q == $past(hi_q) + PB'(1)))
		else $error("upper bound did not advance");

	a_resp_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

endmodule

@@ src/range_distinct_counter.sv @@
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                               tuser
// s_       in   position, new_value, range_lo, range_hi, pad      kind
// m_       out  distinct_count, pad                               range_error
//
// After reset the histogram is swept to zero, one entry a cycle, with s_tready
// low. Write outside the window: the value store only. Write inside the window:
// the old value's histogram entry is decremented, then the new value's is
// incremented and the value store written. Query: the window moves one position
// per step, the first query's single-position load included (value store read,
// histogram read, histogram write, decide).
// A result waits in the output register; the next beat is taken meanwhile, and
// a following query stalls only while that register is still full.

module range_distinct_counter #(
	parameter int POSITION_BITS = 13,
	parameter int VALUE_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// position, new_value, range_lo, range_hi
	input  logic [8*(((3*POSITION_BITS+VALUE_BITS)+7)/8)-1:0] s_tdata,
	// kind
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// distinct_count
	output logic [rdc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// range_error
	output logic                            m_tuser
);

	localparam int PB = POSITION_BITS;
	localparam int VB = VALUE_BITS;

	rdc_pkg::cmd_t             cmd;
	rdc_pkg::status_t          st;
	logic [rdc_pkg::CNT_W-1:0] count;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rdc_dp #(
		.PB (PB),
		.VB (VB)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.kind           (s_tuser),
		.position       (s_tdata[PB-1:0]),
		.new_value      (s_tdata[PB+VB-1:PB]),
		.range_lo       (s_tdata[2*PB+VB-1:PB+VB]),
		.range_hi       (s_tdata[3*PB+VB-1:2*PB+VB]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.distinct_count (count),
		.range_error    (m_tuser)
	);

	assign m_tdata = {{(rdc_pkg::OUT_TDATA_W-rdc_pkg::CNT_W){1'b0}}, count};

endmodule
